FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent check macros for the colorizer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is asserted
`define ASSERT_HOLD(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/pch_pkg.sv
// ----------------------------------------------------------------------------
// pch_pkg
// types, constants and helper functions for the hsl colorizer
// ----------------------------------------------------------------------------
package pch_pkg;

	localparam int PIX_W = 8;
	localparam int CH_N  = 3;
	localparam int W_W   = 17;
	localparam int M_W   = 15;
	localparam int N_W   = 21;
	localparam int Q_W   = 43;

	localparam logic [W_W-1:0] W_MAX = 17'd65536;

	localparam logic [8:0]       HUE_RESET   = 9'd180;
	localparam logic [6:0]       SAT_RESET   = 7'd50;
	localparam logic signed [7:0] LIGHT_RESET = 8'sd0;
	localparam logic [W_W-1:0]   WR_RESET    = 17'd13933;
	localparam logic [W_W-1:0]   WG_RESET    = 17'd46872;
	localparam logic [W_W-1:0]   WB_RESET    = 17'd4732;

	// floor(x/100) for x below 25600, floor(x/6000) for x below 2^21
	localparam logic [12:0] RECIP_100  = 13'd5243;
	localparam logic [21:0] RECIP_6000 = 22'd2863312;
	localparam int          Q_LSB      = 34;

	localparam logic [M_W-1:0] M_MAX = 15'd25500;

	typedef enum logic [2:0] {
		REG_HUE      = 3'd0,
		REG_SAT      = 3'd1,
		REG_LIGHT    = 3'd2,
		REG_WEIGHT_R = 3'd3,
		REG_WEIGHT_G = 3'd4,
		REG_WEIGHT_B = 3'd5
	} cfg_reg_t;

	// settings derived from the registers, used by the later stages
	typedef struct packed {
		logic [6:0]            sat;
		logic [6:0]            scale;
		logic [7:0]            offset;
		logic [CH_N-1:0][5:0]  slope;
	} cfg_t;

	function automatic logic [7:0] div100(input logic [14:0] x);
		logic [27:0] p;
		p = 28'(x) * 28'(RECIP_100);
		return p[26:19];
	endfunction

	// weight of (m2-m1) in sixtieths for a channel angle in 0..360
	function automatic logic [5:0] hue_slope(input logic [8:0] d);
		logic [8:0] r;
		if (d < 9'd60) begin
			r = d;
		end else if (d < 9'd180) begin
			r = 9'd60;
		end else if (d < 9'd240) begin
			r = 9'd240 - d;
		end else begin
			r = 9'd0;
		end
		return r[5:0];
	endfunction

endpackage

FILE: sv/pch_cfg.sv
// ----------------------------------------------------------------------------
// pch_cfg
// register file and derived settings for the colorizer
// ----------------------------------------------------------------------------
module pch_cfg import pch_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [2:0]                 cfg_index,
	input  logic [W_W-1:0]             cfg_data,
	output logic [CH_N-1:0][W_W-1:0]   weight,
	output cfg_t                       cfg
);

	logic [8:0]           hue_q;
	logic [6:0]           sat_q;
	logic signed [7:0]    light_q;
	logic [W_W-1:0]       wr_q, wg_q, wb_q;
	cfg_t                 cfg_q;
	cfg_t                 cfg_d;

	logic [8:0]           h;
	logic [8:0]           d_r, d_b;
	logic signed [7:0]    qc;
	logic [6:0]           mag;
	logic [14:0]          ceil_arg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q   <= HUE_RESET;
			sat_q   <= SAT_RESET;
			light_q <= LIGHT_RESET;
			wr_q    <= WR_RESET;
			wg_q    <= WG_RESET;
			wb_q    <= WB_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HUE:      hue_q   <= cfg_data[8:0];
				REG_SAT:      sat_q   <= cfg_data[6:0];
				REG_LIGHT:    light_q <= signed'(cfg_data[7:0]);
				REG_WEIGHT_R: wr_q    <= cfg_data;
				REG_WEIGHT_G: wg_q    <= cfg_data;
				REG_WEIGHT_B: wb_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// weights feed the first stage directly
	always_comb begin
		weight[0] = (wr_q > W_MAX) ? W_MAX : wr_q;
		weight[1] = (wg_q > W_MAX) ? W_MAX : wg_q;
		weight[2] = (wb_q > W_MAX) ? W_MAX : wb_q;
	end

	always_comb begin
		h   = (hue_q >= 9'd360) ? (hue_q - 9'd360) : hue_q;
		d_r = (h > 9'd240) ? (h - 9'd240) : (h + 9'd120);
		d_b = (h < 9'd120) ? (h + 9'd240) : (h - 9'd120);

		if (light_q > 8'sd100) begin
			qc = 8'sd100;
		end else if (light_q < -8'sd100) begin
			qc = -8'sd100;
		end else begin
			qc = light_q;
		end
		mag      = qc[7] ? 7'(-qc) : 7'(qc);
		ceil_arg = 15'(7'd100 - mag) * 15'd255 + 15'd99;

		cfg_d.sat      = (sat_q > 7'd100) ? 7'd100 : sat_q;
		cfg_d.scale    = 7'd100 - mag;
		// toward white adds back the headroom the scaling removed
		cfg_d.offset   = (!qc[7] && qc != 8'sd0) ? (8'd255 - div100(ceil_arg)) : 8'd0;
		cfg_d.slope[0] = hue_slope(d_r);
		cfg_d.slope[1] = hue_slope(h);
		cfg_d.slope[2] = hue_slope(d_b);
	end

	always_ff @(posedge clk) begin
		cfg_q <= cfg_d;
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/pch_luma.sv
// ----------------------------------------------------------------------------
// pch_luma
// weighted luminance and lightness shift, four pipeline stages
// ----------------------------------------------------------------------------
module pch_luma import pch_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [3:0][PIX_W-1:0]      in_px,
	input  logic [CH_N-1:0][W_W-1:0]   weight,
	input  cfg_t                       cfg,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [PIX_W-1:0]           out_lum,
	output logic [PIX_W-1:0]           out_alpha
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	logic [CH_N-1:0][24:0]  pr_s1;
	logic [PIX_W-1:0]       a_s1, a_s2, a_s3, a_s4;
	logic [PIX_W-1:0]       lum_s2, lum_s4;
	logic [14:0]            prod_s3;

	logic [9:0]             sum;
	logic [8:0]             lum_add;

	// a stage moves when it is empty or its successor moves
	assign adv_s4   = !v_s4 || out_ready;
	assign adv_s3   = !v_s3 || adv_s4;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
		end
	end

	always_comb begin
		sum = 10'(pr_s1[0][24:16]) + 10'(pr_s1[1][24:16]) + 10'(pr_s1[2][24:16]);
		lum_add = 9'(div100(prod_s3)) + 9'(cfg.offset);
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			for (int c = 0; c < CH_N; c++) begin
				pr_s1[c] <= 25'(in_px[c]) * 25'(weight[c]);
			end
			a_s1 <= in_px[3];
		end
		if (adv_s2) begin
			lum_s2 <= (sum > 10'd255) ? 8'd255 : sum[7:0];
			a_s2   <= a_s1;
		end
		if (adv_s3) begin
			prod_s3 <= 15'(lum_s2) * 15'(cfg.scale);
			a_s3    <= a_s2;
		end
		if (adv_s4) begin
			lum_s4 <= lum_add[7:0];
			a_s4   <= a_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_lum   = lum_s4;
	assign out_alpha = a_s4;

endmodule

FILE: sv/pch_hsl.sv
// ----------------------------------------------------------------------------
// pch_hsl
// hsl to rgb conversion of the adjusted luminance, three pipeline stages
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pch_hsl import pch_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [PIX_W-1:0]            in_lum,
	input  logic [PIX_W-1:0]            in_alpha,
	input  cfg_t                        cfg,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [CH_N-1:0][PIX_W-1:0]  out_px,
	output logic [PIX_W-1:0]            out_alpha
);

	logic v_s5, v_s6, v_s7;
	logic adv_s5, adv_s6, adv_s7;

	logic [M_W-1:0]             m1_s5, m2_s5;
	logic [CH_N-1:0][N_W-1:0]   n_s6;
	logic [CH_N-1:0][Q_W-1:0]   q_s7;
	logic [PIX_W-1:0]           a_s5, a_s6, a_s7;

	logic                       lo;
	logic [7:0]                 op_x, op_y;
	logic [15:0]                prod, m2_w, m1_w;
	logic [M_W-1:0]             diff;

	assign adv_s7   = !v_s7 || out_ready;
	assign adv_s6   = !v_s6 || adv_s7;
	assign adv_s5   = !v_s5 || adv_s6;
	assign in_ready = adv_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (adv_s5) v_s5 <= in_valid;
			if (adv_s6) v_s6 <= v_s5;
			if (adv_s7) v_s7 <= v_s6;
		end
	end

	// m2 = l*(100+s) for the dark half, 100*l + s*(255-l) for the bright half
	always_comb begin
		lo   = (in_lum <= 8'd127);
		op_x = lo ? in_lum : (8'd255 - in_lum);
		op_y = lo ? (8'd100 + 8'(cfg.sat)) : 8'(cfg.sat);
		prod = 16'(op_x) * 16'(op_y);
		m2_w = lo ? prod : (16'(in_lum) * 16'd100 + prod);
		m1_w = 16'(in_lum) * 16'd200 - m2_w;
		diff = m2_s5 - m1_s5;
	end

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			m2_s5 <= m2_w[M_W-1:0];
			m1_s5 <= m1_w[M_W-1:0];
			a_s5  <= in_alpha;
		end
		if (adv_s6) begin
			for (int c = 0; c < CH_N; c++) begin
				n_s6[c] <= N_W'(m1_s5) * N_W'(60) + N_W'(diff) * N_W'(cfg.slope[c]);
			end
			a_s6 <= a_s5;
		end
		if (adv_s7) begin
			for (int c = 0; c < CH_N; c++) begin
				q_s7[c] <= Q_W'(n_s6[c]) * Q_W'(RECIP_6000);
			end
			a_s7 <= a_s6;
		end
	end

	always_comb begin
		for (int c = 0; c < CH_N; c++) begin
			out_px[c] = q_s7[c][Q_LSB+PIX_W-1:Q_LSB];
		end
	end

	assign out_valid = v_s7;
	assign out_alpha = a_s7;

	`ASSERT_HOLD(a_m_order, clk, arst_n, v_s5 |-> (m2_s5 >= m1_s5), "m2 below m1")
	`ASSERT_HOLD(a_m_range, clk, arst_n, v_s5 |-> (m2_s5 <= M_MAX), "m2 above full scale")
	`ASSERT_HOLD(a_q_range, clk, arst_n, v_s7 |-> ((q_s7[0][Q_W-1] | q_s7[1][Q_W-1] | q_s7[2][Q_W-1]) == 1'b0), "channel quotient above 255")
	`ASSERT_NEXT(a_advance, clk, arst_n, v_s6 && adv_s7, v_s7, "item dropped entering stage 7")

endmodule

FILE: sv/pixel_colorize_hsl.sv
// ----------------------------------------------------------------------------
// pixel_colorize_hsl
// rgba pixel colorizer: weighted luminance, lightness shift, hsl to rgb
// ----------------------------------------------------------------------------
// Fully pipelined in four luminance stages and three hsl stages, all but
// the luminance sum stage bound by a multiply; one pixel is accepted every
// clock cycle until back-pressure fills the pipeline. Back-pressure on the
// output stalls only the stages that hold items, so bubbles still absorb input.
// The user must write registers through the cfg port only while the stream
// is idle; the block itself does not enforce this. Derived hue, saturation
// and lightness settings settle in the cycle after a write. Alpha is carried
// through unchanged.
module pixel_colorize_hsl import pch_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [31:0]     s_axis_tdata,   // in_red, in_green, in_blue, in_alpha
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [31:0]     m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [W_W-1:0]  cfg_data
);

	logic [CH_N-1:0][W_W-1:0]   weight;
	cfg_t                       cfg;
	logic                       mid_valid, mid_ready;
	logic [PIX_W-1:0]           mid_lum, mid_alpha;
	logic [CH_N-1:0][PIX_W-1:0] out_px;
	logic [PIX_W-1:0]           out_alpha;

	pch_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.weight    (weight),
		.cfg       (cfg)
	);

	pch_luma u_luma (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_px     (s_axis_tdata),
		.weight    (weight),
		.cfg       (cfg),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_lum   (mid_lum),
		.out_alpha (mid_alpha)
	);

	pch_hsl u_hsl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_lum    (mid_lum),
		.in_alpha  (mid_alpha),
		.cfg       (cfg),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_px    (out_px),
		.out_alpha (out_alpha)
	);

	assign m_axis_tdata = {out_alpha, out_px[2], out_px[1], out_px[0]};

endmodule

FILE: tb/tb_pixel_colorize_hsl.sv
// ----------------------------------------------------------------------------
// tb_pixel_colorize_hsl
// self-checking bench for the hsl pixel colorizer
// ----------------------------------------------------------------------------
// A directed table walks reset values, register extremes, out-of-range
// register writes and unused indexes. Random phases follow, each with fresh
// registers and one of three idle profiles on the two streams. Each result is
// compared per channel with a listed value or a fixed-point colorize predictor.
module tb_pixel_colorize_hsl import pch_pkg::*; ();

	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 128;
	localparam int LONG_HOLD   = 120;
	localparam int TAIL_CYCLES = 30;

	// packed so that red lands in the low byte of tdata
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef enum bit {ROW_PIXEL, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [2:0] idx;
		logic [W_W-1:0] val;
		pixel_t     px;
		bit         known;
		pixel_t     want;
	} step_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           s_axis_tvalid = 1'b0;
	logic           s_axis_tready;
	logic [31:0]    s_axis_tdata = '0;   // in_red, in_green, in_blue, in_alpha
	logic           m_axis_tvalid;
	logic           m_axis_tready = 1'b0;
	logic [31:0]    m_axis_tdata;        // out_red, out_green, out_blue, out_alpha
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [2:0]     cfg_index = '0;
	logic [W_W-1:0] cfg_data = '0;

	// register copy used by the predictor
	logic [8:0]        hue_reg   = HUE_RESET;
	logic [6:0]        sat_reg   = SAT_RESET;
	logic signed [7:0] light_reg = LIGHT_RESET;
	logic [W_W-1:0]    wt_red    = WR_RESET;
	logic [W_W-1:0]    wt_green  = WG_RESET;
	logic [W_W-1:0]    wt_blue   = WB_RESET;

	pixel_t pending_pixels[$];
	step_t  directed[$];
	int     mismatches   = 0;
	int     src_idle_pct = 0;
	int     snk_idle_pct = 0;
	bit     hold_req     = 1'b0;
	int     hold_left    = 0;

	pixel_colorize_hsl u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("pixel_colorize_hsl test failed");
		$finish;
	end

	function automatic longint cap_weight(logic [W_W-1:0] w);
		return (w > W_MAX) ? longint'(W_MAX) : longint'(w);
	endfunction

	// 255 times one hsl channel, truncated, for channel angle d
	function automatic logic [7:0] hsl_level(longint m1, longint m2, longint d);
		longint v;
		if (d > 360) d -= 360;
		else if (d < 0) d += 360;
		if (d < 60) v = (60 * m1 + (m2 - m1) * d) / 6000;
		else if (d < 180) v = m2 / 100;
		else if (d < 240) v = (60 * m1 + (m2 - m1) * (240 - d)) / 6000;
		else v = m1 / 100;
		return v[7:0];
	endfunction

	function automatic pixel_t colorize_pixel(pixel_t px);
		longint luma, shift, keep, hue, sat, m1, m2;
		pixel_t res;
		luma = ((longint'(px.red) * cap_weight(wt_red)) >> 16)
			+ ((longint'(px.green) * cap_weight(wt_green)) >> 16)
			+ ((longint'(px.blue) * cap_weight(wt_blue)) >> 16);
		if (luma > 255) luma = 255;
		shift = longint'(light_reg);
		if (shift > 100) shift = 100;
		if (shift < -100) shift = -100;
		if (shift > 0) begin
			// scale toward white, offset rounded down
			keep = 100 - shift;
			luma = luma * keep / 100 + 255 - (keep * 255 + 99) / 100;
		end else if (shift < 0) begin
			luma = luma * (100 + shift) / 100;
		end
		hue = longint'(hue_reg) % 360;
		sat = (sat_reg > 7'd100) ? 100 : longint'(sat_reg);
		if (2 * luma <= 255) m2 = luma * (100 + sat);
		else m2 = 100 * luma + 255 * sat - luma * sat;
		m1 = 200 * luma - m2;
		res.red   = hsl_level(m1, m2, hue + 120);
		res.green = hsl_level(m1, m2, hue);
		res.blue  = hsl_level(m1, m2, hue - 120);
		res.alpha = px.alpha;
		return res;
	endfunction

	task automatic note_mismatch(string what, longint got, longint want);
		$display("mismatch on %s: got 0x%0h, want 0x%0h", what, got, want);
		mismatches++;
	endtask

	function automatic step_t pix_row(pixel_t px);
		return '{ROW_PIXEL, REG_HUE, '0, px, 1'b0, '0};
	endfunction

	function automatic step_t pix_known(pixel_t px, pixel_t want);
		return '{ROW_PIXEL, REG_HUE, '0, px, 1'b1, want};
	endfunction

	function automatic step_t reg_row(logic [2:0] idx, logic [W_W-1:0] val);
		return '{ROW_WRITE, idx, val, '0, 1'b0, '0};
	endfunction

	function automatic logic [7:0] rand_channel();
		if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(255));
	endfunction

	task automatic drain();
		while (pending_pixels.size() != 0) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(logic [2:0] idx, logic [W_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_HUE:      hue_reg   = val[8:0];
			REG_SAT:      sat_reg   = val[6:0];
			REG_LIGHT:    light_reg = val[7:0];
			REG_WEIGHT_R: wt_red    = val;
			REG_WEIGHT_G: wt_green  = val;
			REG_WEIGHT_B: wt_blue   = val;
			default: ;
		endcase
	endtask

	// leaves tvalid high so back-to-back items need no extra assignment
	task automatic send_pixel(pixel_t px, bit known, pixel_t want);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_pixels.push_back(known ? want : colorize_pixel(px));
	endtask

	task automatic randomize_regs();
		int mode, light, w_r, w_g;
		write_reg(REG_HUE, {8'($urandom),
			9'(($urandom_range(9) == 0) ? $urandom_range(511, 360) : $urandom_range(359))});
		mode = $urandom_range(5);
		write_reg(REG_SAT, {10'($urandom), (mode == 0) ? 7'd0 : (mode == 1) ? 7'd100 :
			(mode == 2) ? 7'($urandom_range(127, 101)) : 7'($urandom_range(100))});
		mode = $urandom_range(7);
		light = (mode == 0) ? $urandom_range(255) : (mode == 1) ? 0 :
			$urandom_range(200) - 100;
		write_reg(REG_LIGHT, {9'($urandom), 8'(light)});
		mode = $urandom_range(5);
		if (mode <= 2) begin
			// weights summing to one keep the luminance spread over the range
			w_r = $urandom_range(32768);
			w_g = $urandom_range(65536 - w_r);
			write_reg(REG_WEIGHT_R, 17'(w_r));
			write_reg(REG_WEIGHT_G, 17'(w_g));
			write_reg(REG_WEIGHT_B, 17'(65536 - w_r - w_g));
		end else if (mode == 3) begin
			write_reg(REG_WEIGHT_R, WR_RESET);
			write_reg(REG_WEIGHT_G, WG_RESET);
			write_reg(REG_WEIGHT_B, WB_RESET);
		end else begin
			write_reg(REG_WEIGHT_R, 17'($urandom));
			write_reg(REG_WEIGHT_G, 17'($urandom));
			write_reg(REG_WEIGHT_B, 17'($urandom));
		end
	endtask

	always @(posedge clk) begin : result_check
		pixel_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_pixels.size() == 0) begin
				note_mismatch("unexpected result", got, 0);
			end else begin
				want = pending_pixels.pop_front();
				if (got.red != want.red) note_mismatch("red", got.red, want.red);
				if (got.green != want.green) note_mismatch("green", got.green, want.green);
				if (got.blue != want.blue) note_mismatch("blue", got.blue, want.blue);
				if (got.alpha != want.alpha) note_mismatch("alpha", got.alpha, want.alpha);
			end
		end
		// long hold-off so the pipeline fills and stalls its input
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	initial begin
		// pixel words read 0xAABBGGRR
		directed = '{
			pix_known(32'h0000_0000, 32'h0000_0000),  // black after reset
			pix_row(32'hFFFF_FFFF),
			pix_row(32'hA500_00FF),
			pix_row(32'h5A00_FF00),
			pix_row(32'h80FF_0000),
			reg_row(REG_WEIGHT_R, 17'd65536),
			reg_row(REG_WEIGHT_G, 17'd65536),
			reg_row(REG_WEIGHT_B, 17'd65536),
			reg_row(REG_HUE, 17'd0),
			reg_row(REG_SAT, 17'd100),
			pix_row(32'h01FF_FFFF),                    // weighted sum clips at 255
			pix_row(32'h3C20_4080),
			pix_row(32'h0001_0101),
			// every register past its range
			reg_row(REG_HUE, 17'd511),
			reg_row(REG_SAT, 17'd127),
			reg_row(REG_LIGHT, 17'h0007F),
			reg_row(REG_WEIGHT_R, 17'h1FFFF),
			reg_row(REG_WEIGHT_G, 17'h1FFFF),
			reg_row(REG_WEIGHT_B, 17'h1FFFF),
			pix_known(32'hFF03_C811, 32'hFFFF_FFFF),  // full shift to white
			reg_row(REG_LIGHT, 17'h00080),             // -128 clips to -100
			pix_known(32'h7FFF_FFFF, 32'h7F00_0000),
			reg_row(REG_LIGHT, 17'h00001),
			reg_row(REG_HUE, 17'd359),
			reg_row(REG_SAT, 17'd0),
			pix_row(32'h1080_8080),
			pix_row(32'h2000_0000),
			reg_row(REG_LIGHT, 17'h000FF),
			reg_row(REG_HUE, 17'd120),
			reg_row(REG_SAT, 17'd100),
			reg_row(REG_WEIGHT_R, 17'd0),
			reg_row(REG_WEIGHT_G, 17'd0),
			reg_row(REG_WEIGHT_B, 17'd0),
			pix_known(32'h99FF_FFFF, 32'h9900_0000),  // zero weights
			reg_row(REG_WEIGHT_R, WR_RESET),
			reg_row(REG_WEIGHT_G, WG_RESET),
			reg_row(REG_WEIGHT_B, WB_RESET),
			reg_row(REG_HUE, 17'd240),
			reg_row(REG_LIGHT, 17'h00064),             // exactly +100
			pix_known(32'h4412_3456, 32'h44FF_FFFF),
			reg_row(REG_LIGHT, 17'h0009C),             // exactly -100
			pix_known(32'h55AB_CDEF, 32'h5500_0000),
			reg_row(REG_LIGHT, 17'h00000),
			reg_row(REG_HUE, 17'd60),
			reg_row(REG_SAT, 17'd50),
			pix_row(32'h00C0_8040),
			// unused indexes must leave the registers alone
			reg_row(REG_SPARE_6, 17'h1FFFF),
			reg_row(REG_SPARE_7, 17'h1FFFF),
			pix_row(32'h00C0_8040),
			reg_row(REG_HUE, 17'd300),
			pix_row(32'hEE7F_7F7F),
			pix_row(32'hEE80_8080)
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		src_idle_pct = 8;
		snk_idle_pct = 59;
		foreach (directed[i]) begin
			if (directed[i].kind == ROW_WRITE) begin
				if (i == 0 || directed[i-1].kind != ROW_WRITE) begin
					s_axis_tvalid <= 1'b0;
					drain();
				end
				write_reg(directed[i].idx, directed[i].val);
			end else begin
				if (i > 0 && directed[i-1].kind == ROW_WRITE) cfg_valid <= 1'b0;
				send_pixel(directed[i].px, directed[i].known, directed[i].want);
			end
		end
		s_axis_tvalid <= 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph / 3)
				0: begin
					src_idle_pct = 8;
					snk_idle_pct = 59;
				end
				1: begin
					src_idle_pct = 59;
					snk_idle_pct = 8;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			randomize_regs();
			cfg_valid <= 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph % 3 == 0 && n == 40) hold_req = 1'b1;
				if (n == PHASE_ITEMS / 2) begin
					// sender waits for the pipeline to empty
					s_axis_tvalid <= 1'b0;
					drain();
				end
				send_pixel({rand_channel(), rand_channel(), rand_channel(), rand_channel()},
					1'b0, '0);
			end
			s_axis_tvalid <= 1'b0;
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("pixel_colorize_hsl test passed");
		end else begin
			$display("pixel_colorize_hsl test failed");
		end
		$finish;
	end

endmodule
